/* src/dfad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfad_pkg
// Shared types and constants of the delta frame animation decoder.
// ----------------------------------------------------------------------------
package dfad_pkg;

    localparam int ADDR_WIDTH_DEFAULT = 32;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 16;
    localparam int QUEUE_DEPTH        = 4;
    localparam int ADDR_SUM_W         = 34;
    localparam int PIXEL_ADDR_W       = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANIM_WIDTH       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ANIM_HEIGHT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_FRAME_FULL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_STRIDE    = 3'd6;

    typedef struct packed {
        logic [15:0] frame_count;
        logic [15:0] anim_width;
        logic [15:0] anim_height;
        logic        first_frame_full;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] screen_stride;
    } cfg_t;

    typedef enum logic [2:0] {
        K_NOTE,
        K_START,
        K_KEYPIX,
        K_LITPIX,
        K_SKIP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        frame_end;
        logic        anim_end;
        logic [15:0] frame_number;
    } cmd_t;

endpackage

/* src/dfad_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfad_front
// Accepts stream bytes, tracks chunk framing and classifies each byte.
// ----------------------------------------------------------------------------
module dfad_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                restart,
    input  dfad_pkg::cfg_t      cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                q_full,
    output logic                push,
    output dfad_pkg::cmd_t      push_cmd
);

    typedef enum logic [1:0] {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] chunk_reg, chunk_next;
    logic [6:0]  lit_reg, lit_next;
    logic [15:0] frame_reg, frame_next;
    logic        finished_reg, finished_next;

    assign s_tready = !q_full;

    always_comb begin
        logic        accept;
        logic        key;
        logic        fend_hit;
        logic [15:0] chunk_val;
        logic [15:0] chunk_dec;
        accept        = s_tvalid && !q_full;
        key           = (frame_reg == 16'd0) && cfg.first_frame_full;
        fend_hit      = 1'b0;
        chunk_val     = {s_tdata, len_lo_reg};
        chunk_dec     = chunk_reg - 16'd1;
        phase_next    = phase_reg;
        len_lo_next   = len_lo_reg;
        chunk_next    = chunk_reg;
        lit_next      = lit_reg;
        frame_next    = frame_reg;
        finished_next = finished_reg;
        push          = 1'b0;
        push_cmd.kind         = dfad_pkg::K_NOTE;
        push_cmd.data         = s_tdata;
        push_cmd.frame_end    = 1'b0;
        push_cmd.anim_end     = 1'b0;
        push_cmd.frame_number = frame_reg;
        if (accept && !finished_reg) begin
            case (phase_reg)
                PH_LEN_LO: begin
                    if (!key && (frame_reg >= cfg.frame_count)) begin
                        finished_next = 1'b1;
                    end else begin
                        len_lo_next = s_tdata;
                        phase_next  = PH_LEN_HI;
                        push        = 1'b1;
                    end
                end
                PH_LEN_HI: begin
                    chunk_next    = chunk_val;
                    lit_next      = 7'd0;
                    phase_next    = PH_BODY;
                    push          = 1'b1;
                    push_cmd.kind = dfad_pkg::K_START;
                    fend_hit      = (chunk_val == 16'd0);
                end
                PH_BODY: begin
                    chunk_next = chunk_dec;
                    push       = 1'b1;
                    if (key) begin
                        push_cmd.kind = dfad_pkg::K_KEYPIX;
                    end else if (lit_reg != 7'd0) begin
                        push_cmd.kind = dfad_pkg::K_LITPIX;
                        lit_next      = lit_reg - 7'd1;
                    end else if (s_tdata[7]) begin
                        push_cmd.kind = dfad_pkg::K_SKIP;
                    end else begin
                        lit_next = s_tdata[6:0];
                    end
                    fend_hit = (chunk_dec == 16'd0);
                end
                default: begin
                    phase_next = PH_LEN_LO;
                end
            endcase
            if (fend_hit) begin
                lit_next           = 7'd0;
                phase_next         = PH_LEN_LO;
                frame_next         = frame_reg + 16'd1;
                push_cmd.frame_end = 1'b1;
                if (frame_next >= cfg.frame_count) begin
                    finished_next     = 1'b1;
                    push_cmd.anim_end = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            phase_reg    <= PH_LEN_LO;
            len_lo_reg   <= 8'd0;
            chunk_reg    <= 16'd0;
            lit_reg      <= 7'd0;
            frame_reg    <= 16'd0;
            finished_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            len_lo_reg   <= len_lo_next;
            chunk_reg    <= chunk_next;
            lit_reg      <= lit_next;
            frame_reg    <= frame_next;
            finished_reg <= finished_next;
        end
    end

endmodule

/* src/dfad_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfad_queue
// Short command queue between the parsing front and the pixel back end.
// ----------------------------------------------------------------------------
module dfad_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                flush,
    input  logic                push,
    input  dfad_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output dfad_pkg::cmd_t      head_cmd
);

    localparam int PTR_W = $clog2(dfad_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dfad_pkg::QUEUE_DEPTH + 1);

    dfad_pkg::cmd_t   entry_reg [dfad_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(dfad_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        logic do_push;
        logic do_pop;
        do_push     = push && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/dfad_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfad_back
// Keeps the pixel position, forms screen addresses and drives the results.
// ----------------------------------------------------------------------------
module dfad_back #(
    parameter int ADDR_WIDTH = dfad_pkg::ADDR_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                restart,
    input  dfad_pkg::cfg_t                      cfg,
    input  logic                                q_valid,
    input  dfad_pkg::cmd_t                      q_cmd,
    output logic                                q_pop,
    input  logic                                m_tready,
    output logic                                m_valid,
    output logic                                m_pixel_write,
    output logic [dfad_pkg::PIXEL_ADDR_W-1:0]   m_pixel_addr,
    output logic [7:0]                          m_pixel_value,
    output logic                                m_frame_end,
    output logic                                m_anim_end,
    output logic [15:0]                         m_frame_number
);

    localparam int SW = dfad_pkg::ADDR_SUM_W;
    localparam logic [SW-1:0] ADDR_MASK =
        (ADDR_WIDTH >= SW) ? {SW{1'b1}} : ((SW'(1) << ADDR_WIDTH) - SW'(1));

    typedef enum logic {
        B_RUN,
        B_DIV
    } bstate_t;

    bstate_t        state_reg, state_next;
    logic [15:0]    col_reg, col_next;
    logic [15:0]    row_reg, row_next;
    logic [16:0]    x_reg, x_next;
    dfad_pkg::cmd_t hold_reg, hold_next;
    logic           valid_reg, valid_next;
    logic           wr_reg, wr_next;
    logic [dfad_pkg::PIXEL_ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]     val_reg, val_next;
    logic           fend_reg, fend_next;
    logic           aend_reg, aend_next;
    logic [15:0]    fnum_reg, fnum_next;

    logic [16:0]    y_sum;
    logic [32:0]    prod;
    logic [SW-1:0]  addr_sum;
    logic [SW-1:0]  addr_masked;

    assign y_sum       = {1'b0, cfg.origin_y} + {1'b0, row_reg};
    assign prod        = y_sum * cfg.screen_stride;
    assign addr_sum    = {1'b0, prod} + {18'd0, cfg.origin_x} + {18'd0, col_reg};
    assign addr_masked = addr_sum & ADDR_MASK;

    assign m_valid        = valid_reg;
    assign m_pixel_write  = wr_reg;
    assign m_pixel_addr   = addr_reg;
    assign m_pixel_value  = val_reg;
    assign m_frame_end    = fend_reg;
    assign m_anim_end     = aend_reg;
    assign m_frame_number = fnum_reg;

    always_comb begin
        logic        out_ready;
        logic [15:0] col_inc;
        logic [16:0] width17;
        logic [16:0] skip_x;
        out_ready  = !valid_reg || m_tready;
        col_inc    = col_reg + 16'd1;
        width17    = {1'b0, cfg.anim_width};
        skip_x     = {1'b0, col_reg} + {10'd0, q_cmd.data[6:0]};
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        x_next     = x_reg;
        hold_next  = hold_reg;
        valid_next = valid_reg && !m_tready;
        wr_next    = wr_reg;
        addr_next  = addr_reg;
        val_next   = val_reg;
        fend_next  = fend_reg;
        aend_next  = aend_reg;
        fnum_next  = fnum_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_RUN: begin
                if (q_valid && out_ready) begin
                    q_pop      = 1'b1;
                    valid_next = 1'b1;
                    wr_next    = 1'b0;
                    addr_next  = '0;
                    val_next   = 8'd0;
                    fend_next  = q_cmd.frame_end;
                    aend_next  = q_cmd.anim_end;
                    fnum_next  = q_cmd.frame_number;
                    case (q_cmd.kind)
                        dfad_pkg::K_START: begin
                            col_next = 16'd0;
                            row_next = 16'd0;
                        end
                        dfad_pkg::K_KEYPIX: begin
                            if ((cfg.anim_width != 16'd0) && (row_reg < cfg.anim_height)) begin
                                wr_next   = 1'b1;
                                addr_next = addr_masked[dfad_pkg::PIXEL_ADDR_W-1:0];
                                val_next  = q_cmd.data;
                                if (col_inc >= cfg.anim_width) begin
                                    col_next = 16'd0;
                                    row_next = row_reg + 16'd1;
                                end else begin
                                    col_next = col_inc;
                                end
                            end
                        end
                        dfad_pkg::K_LITPIX: begin
                            wr_next   = 1'b1;
                            addr_next = addr_masked[dfad_pkg::PIXEL_ADDR_W-1:0];
                            val_next  = q_cmd.data;
                            if (col_inc >= cfg.anim_width) begin
                                col_next = 16'd0;
                                row_next = row_reg + 16'd1;
                            end else begin
                                col_next = col_inc;
                            end
                        end
                        dfad_pkg::K_SKIP: begin
                            if ((cfg.anim_width != 16'd0) && (skip_x >= width17)) begin
                                valid_next = valid_reg && !m_tready;
                                x_next     = skip_x - width17;
                                row_next   = row_reg + 16'd1;
                                hold_next  = q_cmd;
                                state_next = B_DIV;
                            end else begin
                                col_next = skip_x[15:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_DIV: begin
                if (x_reg >= width17) begin
                    x_next   = x_reg - width17;
                    row_next = row_reg + 16'd1;
                end else if (out_ready) begin
                    col_next   = x_reg[15:0];
                    valid_next = 1'b1;
                    wr_next    = 1'b0;
                    addr_next  = '0;
                    val_next   = 8'd0;
                    fend_next  = hold_reg.frame_end;
                    aend_next  = hold_reg.anim_end;
                    fnum_next  = hold_reg.frame_number;
                    state_next = B_RUN;
                end
            end
            default: begin
                state_next = B_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            state_reg <= B_RUN;
            col_reg   <= 16'd0;
            row_reg   <= 16'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
        x_reg    <= x_next;
        hold_reg <= hold_next;
        wr_reg   <= wr_next;
        addr_reg <= addr_next;
        val_reg  <= val_next;
        fend_reg <= fend_next;
        aend_reg <= aend_next;
        fnum_reg <= fnum_next;
    end

endmodule

/* src/delta_frame_animation_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_frame_animation_decoder
// Decodes a skip/literal delta-frame animation byte stream into pixel writes.
// ----------------------------------------------------------------------------
// The front end takes one stream byte per cycle while its four-entry command
// queue has room, and the back end retires one command per cycle into an
// output register while that register is empty or taken, so literal and control
// bytes flow at one item per cycle unless a skip holds the back end. A skip
// command that runs past the end of a row makes the back end subtract the
// animation width once for every row it crosses, and it takes no new command
// until the skip is done. Every result carries the frame number; tlast marks
// the last item of a frame. Any write to registers 0 to 6 restarts the player
// at frame 0.
module delta_frame_animation_decoder #(
    parameter int ADDR_WIDTH = dfad_pkg::ADDR_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [dfad_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dfad_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] stream_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] pixel_addr, [39:32] pixel_value, [40] anim_end,
    // [56:41] frame_number, [63:57] zero
    output logic [63:0]                       m_tdata,
    output logic                              m_tuser,   // [0] pixel_write
    output logic                              m_tlast    // frame_end
);

    dfad_pkg::cfg_t cfg_reg;
    logic           restart;
    logic           push;
    dfad_pkg::cmd_t push_cmd;
    logic           q_full;
    logic           q_valid;
    dfad_pkg::cmd_t q_cmd;
    logic           q_pop;
    logic [dfad_pkg::PIXEL_ADDR_W-1:0] pixel_addr;
    logic [7:0]     pixel_value;
    logic           anim_end;
    logic [15:0]    frame_number;

    assign restart = cfg_we && (cfg_index <= dfad_pkg::REG_SCREEN_STRIDE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                dfad_pkg::REG_FRAME_COUNT:      cfg_reg.frame_count      <= cfg_wdata;
                dfad_pkg::REG_ANIM_WIDTH:       cfg_reg.anim_width       <= cfg_wdata;
                dfad_pkg::REG_ANIM_HEIGHT:      cfg_reg.anim_height      <= cfg_wdata;
                dfad_pkg::REG_FIRST_FRAME_FULL: cfg_reg.first_frame_full <= cfg_wdata[0];
                dfad_pkg::REG_ORIGIN_X:         cfg_reg.origin_x         <= cfg_wdata;
                dfad_pkg::REG_ORIGIN_Y:         cfg_reg.origin_y         <= cfg_wdata;
                dfad_pkg::REG_SCREEN_STRIDE:    cfg_reg.screen_stride    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    dfad_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (restart),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dfad_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flush      (restart),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    dfad_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .restart        (restart),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .m_tready       (m_tready),
        .m_valid        (m_tvalid),
        .m_pixel_write  (m_tuser),
        .m_pixel_addr   (pixel_addr),
        .m_pixel_value  (pixel_value),
        .m_frame_end    (m_tlast),
        .m_anim_end     (anim_end),
        .m_frame_number (frame_number)
    );

    assign m_tdata = {7'd0, frame_number, anim_end, pixel_value, pixel_addr};

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_full))
        else $error("command pushed into a full queue");

    a_anim_end_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[40]) |-> m_tlast)
        else $error("animation end without frame end");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (!m_tvalid && !q_valid))
        else $error("item left in flight after restart");
`endif

endmodule

/* tb/tb_delta_frame_animation_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_frame_animation_decoder
// Self-checking testbench for the skip/literal delta-frame animation decoder.
// Animation byte streams are sent one item at a time, and a local decoder
// model predicts the pixel write and frame flags of every accepted byte. A
// checker compares each result item with the oldest prediction. Directed
// frames cover keyframes, skips, literal runs, empty and overrun chunks and
// address wrap. Random animations follow under random configurations, with
// random idling on both sides and a long stall of the result side.
// ----------------------------------------------------------------------------
module tb_delta_frame_animation_decoder;

    import dfad_pkg::*;

    localparam int ITEM_TARGET   = 450;
    localparam int CALM_TAIL     = 80;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 300;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY
    } parse_phase_t;

    typedef struct packed {
        logic        pixel_write;
        logic [31:0] pixel_addr;
        logic [7:0]  pixel_value;
        logic        frame_end;
        logic        anim_end;
        logic [15:0] frame_number;
    } pixel_res_t;

    typedef logic [7:0] stream_bytes_t[$];

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [63:0]            m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    delta_frame_animation_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Decoder model state.
    cfg_t         play_cfg;
    parse_phase_t phase;
    logic [7:0]   len_low;
    logic [16:0]  chunk_left;
    logic [6:0]   lit_left;
    logic [15:0]  col;
    logic [15:0]  row;
    logic [15:0]  cur_frame;
    logic         anim_done;

    pixel_res_t due_results[$];
    int         mismatches    = 0;
    int         sent_items    = 0;
    bit         src_idle      = 1'b1;
    bit         sink_idle     = 1'b1;
    int         sink_hold     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void restart_player();
        phase      = PH_LEN_LO;
        len_low    = '0;
        chunk_left = '0;
        lit_left   = '0;
        col        = '0;
        row        = '0;
        cur_frame  = '0;
        anim_done  = 1'b0;
    endfunction

    function automatic logic [31:0] screen_addr();
        logic [63:0] a;
        a = (64'(play_cfg.origin_y) + 64'(row)) * 64'(play_cfg.screen_stride)
            + 64'(play_cfg.origin_x) + 64'(col);
        return a[31:0];
    endfunction

    // Advances the model by one stream byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] b, output pixel_res_t r);
        logic [16:0] x;
        logic        key;
        r = '0;
        r.frame_number = cur_frame;
        key = (cur_frame == 16'd0) && play_cfg.first_frame_full;
        if (anim_done) return 1'b0;
        case (phase)
            PH_LEN_LO: begin
                if (!key && cur_frame >= play_cfg.frame_count) begin
                    anim_done = 1'b1;
                    return 1'b0;
                end
                len_low = b;
                phase   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                chunk_left  = {1'b0, b, len_low};
                lit_left    = '0;
                col         = '0;
                row         = '0;
                phase       = PH_BODY;
                r.frame_end = (chunk_left == '0);
            end
            default: begin
                chunk_left = chunk_left - 17'd1;
                if ((key && play_cfg.anim_width != 0 && row < play_cfg.anim_height)
                        || (!key && lit_left != 0)) begin
                    r.pixel_write = 1'b1;
                    r.pixel_addr  = screen_addr();
                    r.pixel_value = b;
                    if (!key) lit_left = lit_left - 7'd1;
                    col = col + 16'd1;
                    if (col >= play_cfg.anim_width) begin
                        col = '0;
                        row = row + 16'd1;
                    end
                end else if (!key && b[7]) begin
                    x = {1'b0, col} + 17'(b[6:0]);
                    if (play_cfg.anim_width != 0) begin
                        row = row + 16'(x / play_cfg.anim_width);
                        x   = x % play_cfg.anim_width;
                    end
                    col = x[15:0];
                end else if (!key) begin
                    lit_left = b[6:0];
                end
                r.frame_end = (chunk_left == '0);
            end
        endcase
        if (r.frame_end) begin
            lit_left  = '0;
            phase     = PH_LEN_LO;
            cur_frame = cur_frame + 16'd1;
            if (cur_frame >= play_cfg.frame_count) begin
                anim_done  = 1'b1;
                r.anim_end = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic string res_str(input pixel_res_t r);
        return $sformatf("wr=%0d addr=%h val=%h fend=%0d aend=%0d frame=%0d",
                         r.pixel_write, r.pixel_addr, r.pixel_value,
                         r.frame_end, r.anim_end, r.frame_number);
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    always @(posedge aclk) begin : result_check
        pixel_res_t got;
        pixel_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pixel_write  = m_tuser;
            got.pixel_addr   = m_tdata[31:0];
            got.pixel_value  = m_tdata[39:32];
            got.anim_end     = m_tdata[40];
            got.frame_number = m_tdata[56:41];
            got.frame_end    = m_tlast;
            if (due_results.size() == 0) begin
                flag_mismatch({"unexpected result: ", res_str(got)});
            end else begin
                want = due_results.pop_front();
                if (got !== want || m_tdata[63:57] !== 7'd0) begin
                    flag_mismatch($sformatf("expected %s | got %s pad=%h",
                                            res_str(want), res_str(got),
                                            m_tdata[63:57]));
                end
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial begin : result_sink
        int n;
        forever begin
            if (sink_hold > 0) begin
                n = sink_hold;
                sink_hold = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (!s_tvalid && due_results.size() == 0))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no item accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        pixel_res_t r;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        if (decode_byte(b, r)) begin
            due_results.push_back(r);
        end
    endtask

    task automatic send_chunk(input stream_bytes_t body);
        send_byte(8'(body.size()));
        send_byte(8'(body.size() >> 8));
        foreach (body[i]) send_byte(body[i]);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_FRAME_COUNT:      play_cfg.frame_count      = data;
            REG_ANIM_WIDTH:       play_cfg.anim_width       = data;
            REG_ANIM_HEIGHT:      play_cfg.anim_height      = data;
            REG_FIRST_FRAME_FULL: play_cfg.first_frame_full = data[0];
            REG_ORIGIN_X:         play_cfg.origin_x         = data;
            REG_ORIGIN_Y:         play_cfg.origin_y         = data;
            REG_SCREEN_STRIDE:    play_cfg.screen_stride    = data;
            default:              return;
        endcase
        restart_player();
    endtask

    // The unused index is written last, so it must leave the restart alone.
    task automatic apply_cfg(input cfg_t c);
        cfg_write(REG_FRAME_COUNT, c.frame_count);
        cfg_write(REG_ANIM_WIDTH, c.anim_width);
        cfg_write(REG_ANIM_HEIGHT, c.anim_height);
        cfg_write(REG_FIRST_FRAME_FULL, {15'($urandom), c.first_frame_full});
        cfg_write(REG_ORIGIN_X, c.origin_x);
        cfg_write(REG_ORIGIN_Y, c.origin_y);
        cfg_write(REG_SCREEN_STRIDE, c.screen_stride);
        cfg_write(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic stream_bytes_t make_delta_body(input int len);
        stream_bytes_t body;
        int            sel;
        int            n;
        body = {};
        while (body.size() < len) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                body.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end else begin
                n = (sel == 9) ? $urandom_range(0, 127) : $urandom_range(0, 6);
                body.push_back(8'(n));
                repeat (n) if (body.size() < len) body.push_back(8'($urandom));
            end
        end
        return body;
    endfunction

    function automatic stream_bytes_t make_raw_body(input int len);
        stream_bytes_t body;
        body = {};
        repeat (len) body.push_back(8'($urandom));
        return body;
    endfunction

    task automatic test_directed_frames();
        cfg_t          c;
        stream_bytes_t body;
        c = '{frame_count: 16'd2, anim_width: 16'd3, anim_height: 16'd2,
              first_frame_full: 1'b1, origin_x: 16'd2, origin_y: 16'd1,
              screen_stride: 16'd10};
        apply_cfg(c);
        // Keyframe of six pixels with one spare byte before the chunk end.
        body = {8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F};
        send_chunk(body);
        // Skip, a literal run across a row end, a long wrapping skip, an
        // empty run and a run cut short by the chunk end.
        body = {8'h82, 8'h02, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h7F};
        send_chunk(body);
        send_byte(8'h3C);
        wait_drain();
    endtask

    task automatic test_corner_configs();
        cfg_t          c;
        stream_bytes_t body;
        // No frames at all: the first byte ends the animation silently.
        c = '{frame_count: 16'd0, anim_width: 16'hFFFF, anim_height: 16'hFFFF,
              first_frame_full: 1'b0, origin_x: 16'hFFFF, origin_y: 16'hFFFF,
              screen_stride: 16'hFFFF};
        apply_cfg(c);
        send_byte(8'hFF);
        wait_drain();
        // Keyframe of zero width with a frame count of zero.
        c = '{frame_count: 16'd0, anim_width: 16'd0, anim_height: 16'd1,
              first_frame_full: 1'b1, origin_x: 16'd0, origin_y: 16'd0,
              screen_stride: 16'd0};
        apply_cfg(c);
        body = {8'h42};
        send_chunk(body);
        wait_drain();
        // Zero width deltas at the far corner of the address space.
        c = '{frame_count: 16'hFFFF, anim_width: 16'd0, anim_height: 16'd0,
              first_frame_full: 1'b0, origin_x: 16'hFFFF, origin_y: 16'hFFFF,
              screen_stride: 16'hFFFF};
        apply_cfg(c);
        body = {};
        send_chunk(body);
        body = {8'h81, 8'h01, 8'h5A};
        send_chunk(body);
        wait_drain();
    endtask

    task automatic test_backpressure();
        cfg_t c;
        c = '{frame_count: 16'd3, anim_width: 16'd8, anim_height: 16'd4,
              first_frame_full: 1'b0, origin_x: 16'($urandom),
              origin_y: 16'($urandom), screen_stride: 16'($urandom)};
        apply_cfg(c);
        sink_hold = LONG_HOLD;
        send_chunk(make_delta_body(24));
        // Let the frame drain completely before the rest of the animation.
        wait_drain();
        send_chunk(make_delta_body(12));
        send_chunk(make_delta_body(12));
        wait_drain();
    endtask

    task automatic test_random_animations();
        cfg_t          c;
        int            sel;
        int            nframes;
        int            len;
        int            area;
        stream_bytes_t body;
        while (sent_items < ITEM_TARGET) begin
            sel = $urandom_range(0, 9);
            c.frame_count = (sel == 0) ? 16'd0 : (sel == 9) ? 16'hFFFF
                          : 16'($urandom_range(1, 5));
            sel = $urandom_range(0, 9);
            c.anim_width = (sel == 0) ? 16'd0 : (sel == 1) ? 16'd1
                         : (sel == 2) ? 16'hFFFF : 16'($urandom_range(2, 16));
            c.anim_height = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                          : 16'($urandom_range(0, 4));
            c.first_frame_full = 1'($urandom);
            c.origin_x         = 16'($urandom);
            c.origin_y         = 16'($urandom);
            c.screen_stride    = 16'($urandom);
            apply_cfg(c);
            if (sent_items >= ITEM_TARGET - CALM_TAIL) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end else begin
                src_idle  = 1'($urandom);
                sink_idle = 1'($urandom);
            end
            if (c.frame_count == 16'd0 || c.frame_count == 16'hFFFF)
                nframes = $urandom_range(1, 3);
            else if ($urandom_range(0, 5) == 0)
                nframes = $urandom_range(0, c.frame_count);
            else
                nframes = c.frame_count;
            for (int f = 0; f < nframes; f++) begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                if (f == 0 && c.first_frame_full) begin
                    area = (c.anim_width <= 16'd30 && c.anim_height <= 16'd30)
                         ? int'(c.anim_width) * int'(c.anim_height) : 31;
                    if (area <= 30 && $urandom_range(0, 1) == 0)
                        len = area + $urandom_range(0, 2);
                    body = make_raw_body(len);
                end else begin
                    body = make_delta_body(len);
                end
                send_chunk(body);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            wait_drain();
        end
    endtask

    initial begin : run_tests
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        play_cfg = '0;
        restart_player();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_corner_configs();
        test_backpressure();
        test_random_animations();

        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* delta_frame_animation_decoder.f */
src/dfad_pkg.sv
src/dfad_front.sv
src/dfad_queue.sv
src/dfad_back.sv
src/delta_frame_animation_decoder.sv
tb/tb_delta_frame_animation_decoder.sv
